@@ hw/rtl/ale_pkg.sv @@
// Shared types, codes and default sizes of the array list engine.
`timescale 1ns / 1ps

package ale_pkg;

  localparam int CAPACITY   = 8;
  localparam int DATA_WIDTH = 32;

  typedef enum logic [3:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_BACK  = 4'd1,
    OP_INS_POS   = 4'd2,
    OP_DEL_FRONT = 4'd3,
    OP_DEL_BACK  = 4'd4,
    OP_DEL_POS   = 4'd5,
    OP_SEARCH    = 4'd6,
    OP_READOUT   = 4'd7,
    OP_ROTATE    = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_e;

endpackage

@@ hw/rtl/ale_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ale_ram #(
  parameter int WIDTH = ale_pkg::DATA_WIDTH,
  parameter int DEPTH = ale_pkg::CAPACITY,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/array_list_engine_top.sv @@
// Top level of the array list engine: sequencer, two list banks and result register.
// A failed check, an unknown opcode or a rotate of an empty list reports in the cycle after
// acceptance. Inserts, deletes and searches copy or scan the list element by element (a delete
// that empties the list skips the copy), a rotate first reduces its count modulo the length,
// and a readout gives its items one a cycle.
// Throughput is set by the single RAM read port, one element per cycle; busy_o is high
// meanwhile. Reset empties the list at once; results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module array_list_engine_top #(
  parameter int CAPACITY   = ale_pkg::CAPACITY,
  parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [3:0]            opcode_i,
  input  logic signed [31:0]    value_i,
  input  logic [5:0]            position_i,
  input  logic [15:0]           rotate_count_i,
  output logic                  res_valid_o,
  output ale_pkg::status_e      status_o,
  output logic signed [31:0]    element_o,
  output logic [3:0]            element_position_o,
  output logic [7:0]            hit_mask_o,
  output logic [3:0]            length_o,
  output logic                  last_o
);

  import ale_pkg::*;

  // Index width for the list storage and width of the element count.
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = DATA_WIDTH;

  // Sequencer state and the command in hand.
  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [DW-1:0]   val_q, val_d;
  logic [IW-1:0]   k_q, k_d;          // index of the insert or delete
  logic [IW-1:0]   j_q, j_d;          // destination or scan index
  logic [IW-1:0]   end_q, end_d;      // final index of the pass
  logic [IW-1:0]   rot_ptr_q, rot_ptr_d;
  logic [CW-1:0]   newcnt_q, newcnt_d;
  logic [CW-1:0]   count_q, count_d;
  logic            bank_q, bank_d;    // which RAM holds the live list

  // Restoring modulo unit, one bit of the rotate count each cycle.
  logic [CW-1:0]   rem_q, rem_d;
  logic [15:0]     rot_q, rot_d;
  logic [3:0]      mcnt_q, mcnt_d;
  logic [CW:0]     mod_t;

  // Search accumulators.
  logic            hit_q, hit_d;
  logic [7:0]      hmask_q, hmask_d;

  // Second stage: the cycle in which the registered RAM data is used.
  logic            p_vld_q, p_vld_d;
  logic            p_useval_q, p_useval_d;
  logic [IW-1:0]   p_idx_q, p_idx_d;
  logic            p_last_q, p_last_d;

  // Result register.
  logic            res_valid_q, res_valid_d;
  status_e         res_status_q, res_status_d;
  logic [31:0]     res_elem_q, res_elem_d;
  logic [3:0]      res_epos_q, res_epos_d;
  logic [7:0]      res_mask_q, res_mask_d;
  logic [3:0]      res_len_q, res_len_d;
  logic            res_last_q, res_last_d;

  // RAM side.
  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr;
  logic [DW-1:0]   wr_data, rdata, rdata0, rdata1;

  logic [DW-1:0]   value_ext;
  logic            is_full, is_empty, pos_ok;

  // The input word is sign-extended or cut to the storage width.
  assign value_ext = DW'(value_i);
  assign is_full   = (count_q == CW'(CAPACITY));
  assign is_empty  = (count_q == '0);
  assign pos_ok    = (position_i != '0) && (32'(position_i) <= 32'(count_q));
  assign rdata     = bank_q ? rdata1 : rdata0;
  assign wr_data   = p_useval_q ? val_q : rdata;

  // Every change but the delete of the only element copies from the live bank into the other,
  // with the source index chosen to open a gap, close one or rotate; the banks swap at the end.
  ale_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (wr_en && bank_q),
    .waddr_i (p_idx_q),
    .wdata_i (wr_data),
    .re_i    (rd_en && !bank_q),
    .raddr_i (rd_addr),
    .rdata_o (rdata0)
  );

  ale_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (wr_en && !bank_q),
    .waddr_i (p_idx_q),
    .wdata_i (wr_data),
    .re_i    (rd_en && bank_q),
    .raddr_i (rd_addr),
    .rdata_o (rdata1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bank_q      <= 1'b0;
      p_vld_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bank_q      <= bank_d;
      p_vld_q     <= p_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    val_q        <= val_d;
    k_q          <= k_d;
    j_q          <= j_d;
    end_q        <= end_d;
    rot_ptr_q    <= rot_ptr_d;
    newcnt_q     <= newcnt_d;
    rem_q        <= rem_d;
    rot_q        <= rot_d;
    mcnt_q       <= mcnt_d;
    hit_q        <= hit_d;
    hmask_q      <= hmask_d;
    p_useval_q   <= p_useval_d;
    p_idx_q      <= p_idx_d;
    p_last_q     <= p_last_d;
    res_status_q <= res_status_d;
    res_elem_q   <= res_elem_d;
    res_epos_q   <= res_epos_d;
    res_mask_q   <= res_mask_d;
    res_len_q    <= res_len_d;
    res_last_q   <= res_last_d;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    val_d        = val_q;
    k_d          = k_q;
    j_d          = j_q;
    end_d        = end_q;
    rot_ptr_d    = rot_ptr_q;
    newcnt_d     = newcnt_q;
    count_d      = count_q;
    bank_d       = bank_q;
    rem_d        = rem_q;
    rot_d        = rot_q;
    mcnt_d       = mcnt_q;
    mod_t        = {rem_q, rot_q[15]};
    hit_d        = hit_q;
    hmask_d      = hmask_q;
    p_vld_d      = 1'b0;
    p_useval_d   = 1'b0;
    p_idx_d      = p_idx_q;
    p_last_d     = p_last_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_elem_d   = res_elem_q;
    res_epos_d   = res_epos_q;
    res_mask_d   = res_mask_q;
    res_len_d    = res_len_q;
    res_last_d   = res_last_q;
    rd_en        = 1'b0;
    rd_addr      = j_q;
    wr_en        = 1'b0;

    // Second stage: consume the element read in the previous cycle.
    if (p_vld_q) begin
      case (op_q) inside
        OP_SEARCH: begin
          if (rdata == val_q) begin
            hit_d = 1'b1;
            for (int b = 0; b < 8; b++) begin
              if (32'(p_idx_q) == b) begin
                hmask_d[b] = 1'b1;
              end
            end
          end
        end
        OP_READOUT: begin
          res_valid_d  = 1'b1;
          res_status_d = ST_OK;
          res_elem_d   = 32'(rdata);
          res_epos_d   = 4'(32'(p_idx_q) + 1);
          res_mask_d   = '0;
          res_len_d    = 4'(count_q);
          res_last_d   = p_last_q;
        end
        default: begin
          wr_en = 1'b1;
        end
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d         = op_e'(opcode_i);
          val_d        = value_ext;
          j_d          = '0;
          hit_d        = 1'b0;
          hmask_d      = '0;
          newcnt_d     = count_q;
          end_d        = IW'(count_q - CW'(1));
          res_status_d = ST_OK;
          res_elem_d   = '0;
          res_epos_d   = '0;
          res_mask_d   = '0;
          res_len_d    = 4'(count_q);
          res_last_d   = 1'b1;
          unique case (op_e'(opcode_i))
            OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
              k_d      = (op_e'(opcode_i) == OP_INS_FRONT) ? '0 :
                         (op_e'(opcode_i) == OP_INS_BACK)  ? IW'(count_q) :
                                                             IW'(position_i - 6'd1);
              newcnt_d = count_q + CW'(1);
              end_d    = IW'(count_q);
              if (is_full) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_FULL;
              end else if ((op_e'(opcode_i) == OP_INS_POS) && !pos_ok) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_BADPOS;
              end else begin
                state_d = S_RUN;
              end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
              k_d      = (op_e'(opcode_i) == OP_DEL_FRONT) ? '0 :
                         (op_e'(opcode_i) == OP_DEL_BACK)  ? IW'(count_q - CW'(1)) :
                                                             IW'(position_i - 6'd1);
              newcnt_d = count_q - CW'(1);
              end_d    = IW'(count_q - CW'(2));
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else if ((op_e'(opcode_i) == OP_DEL_POS) && !pos_ok) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_BADPOS;
              end else if (count_q == CW'(1)) begin
                // Nothing is left to copy once the only element goes.
                state_d = S_DONE;
              end else begin
                state_d = S_RUN;
              end
            end
            OP_SEARCH, OP_READOUT: begin
              if (is_empty) begin
                res_valid_d  = 1'b1;
                res_status_d = ST_EMPTY;
              end else begin
                state_d = S_RUN;
              end
            end
            OP_ROTATE: begin
              if (is_empty) begin
                res_valid_d = 1'b1;
              end else begin
                rot_d   = rotate_count_i;
                rem_d   = '0;
                mcnt_d  = '0;
                state_d = S_MOD;
              end
            end
            default: begin
              // An unknown opcode leaves the list as it is.
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      S_MOD: begin
        if (mod_t >= {1'b0, count_q}) begin
          mod_t = mod_t - {1'b0, count_q};
        end
        rem_d  = CW'(mod_t);
        rot_d  = {rot_q[14:0], 1'b0};
        mcnt_d = mcnt_q + 4'd1;
        if (mcnt_q == 4'd15) begin
          rot_ptr_d = IW'(CW'(mod_t));
          state_d   = S_RUN;
        end
      end

      S_RUN: begin
        p_vld_d  = 1'b1;
        p_idx_d  = j_q;
        p_last_d = (j_q == end_q);
        case (op_q) inside
          OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (j_q == k_q) begin
              p_useval_d = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = (j_q < k_q) ? j_q : j_q - IW'(1);
            end
          end
          OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
            rd_en   = 1'b1;
            rd_addr = (j_q < k_q) ? j_q : j_q + IW'(1);
          end
          OP_ROTATE: begin
            rd_en     = 1'b1;
            rd_addr   = rot_ptr_q;
            rot_ptr_d = (CW'(rot_ptr_q) == count_q - CW'(1)) ? '0 : rot_ptr_q + IW'(1);
          end
          default: begin
            rd_en   = 1'b1;
            rd_addr = j_q;
          end
        endcase
        j_d = j_q + IW'(1);
        if (j_q == end_q) begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d      = S_IDLE;
        res_status_d = ST_OK;
        res_elem_d   = '0;
        res_epos_d   = '0;
        res_mask_d   = '0;
        res_len_d    = 4'(count_q);
        res_last_d   = 1'b1;
        case (op_q) inside
          OP_SEARCH: begin
            res_valid_d  = 1'b1;
            res_status_d = hit_q ? ST_OK : ST_NOTFOUND;
            res_mask_d   = hmask_q;
          end
          OP_READOUT: begin
            // The final readout item has already gone out from the second stage.
          end
          default: begin
            bank_d      = ~bank_q;
            count_d     = newcnt_q;
            res_valid_d = 1'b1;
            res_len_d   = 4'(newcnt_q);
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o             = (state_q != S_IDLE);
  assign res_valid_o        = res_valid_q;
  assign status_o           = res_status_q;
  assign element_o          = res_elem_q;
  assign element_position_o = res_epos_q;
  assign hit_mask_o         = res_mask_q;
  assign length_o           = res_len_q;
  assign last_o             = res_last_q;

`ifndef SYNTHESIS
  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("element count above capacity");

  a_bank_swap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q != OP_SEARCH && op_q != OP_READOUT)
      |=> (bank_q != $past(bank_q)))
    else $error("list banks did not swap after a change");

  a_mid_readout : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o)
    else $error("non-final item shown while the engine is idle");

  a_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || res_valid_o))
    else $error("accepted command neither started nor reported");
`endif

endmodule

@@ tb/tb_array_list_engine_top.sv @@
// Self-checking testbench for the array list engine: directed corner cases, then random commands.
`timescale 1ns / 1ps

module tb_array_list_engine_top;
  import ale_pkg::*;

  // A command may stay quiet for a long rotate or a sender gap, but never for this long.
  localparam int QUIET_LIMIT  = 2000;
  // Cycles allowed after the final result, in case anything stray follows it.
  localparam int DRAIN_CYCLES = 64;
  // The lowest opcode that the engine does not decode; it answers with a plain status item.
  localparam logic [3:0] FIRST_UNUSED_OP = OP_ROTATE + 4'd1;

  typedef struct packed {
    status_e     status;
    logic [31:0] element;
    logic [3:0]  element_pos;
    logic [7:0]  hit_mask;
    logic [3:0]  length;
    logic        last;
  } list_result_t;

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               busy_o;
  logic [3:0]         opcode_i       = '0;
  logic signed [31:0] value_i        = '0;
  logic [5:0]         position_i     = '0;
  logic [15:0]        rotate_count_i = '0;
  logic               res_valid_o;
  status_e            status_o;
  logic signed [31:0] element_o;
  logic [3:0]         element_position_o;
  logic [7:0]         hit_mask_o;
  logic [3:0]         length_o;
  logic               last_o;

  // Shadow copy of the list, updated as each command is accepted.
  logic [31:0]  list_words [CAPACITY];
  int unsigned  list_len;
  list_result_t expected_results [$];

  int fail_count      = 0;
  int quiet_cycles    = 0;
  int sender_idle_pct = 0;

  array_list_engine_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .opcode_i           (opcode_i),
    .value_i            (value_i),
    .position_i         (position_i),
    .rotate_count_i     (rotate_count_i),
    .res_valid_o        (res_valid_o),
    .status_o           (status_o),
    .element_o          (element_o),
    .element_position_o (element_position_o),
    .hit_mask_o         (hit_mask_o),
    .length_o           (length_o),
    .last_o             (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Works out the result items of one accepted command and applies it to the shadow list.
  // A read-out of a non-empty list gives one item per element; everything else gives one.
  task automatic predict_list_op(input logic [3:0] op, input logic [31:0] val,
                                 input logic [5:0] pos, input logic [15:0] rot);
    status_e      st;
    logic [7:0]   mask;
    int unsigned  idx;
    int unsigned  shift;
    logic [31:0]  snap [CAPACITY];
    list_result_t res;
    st   = ST_OK;
    mask = '0;
    case (op)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
        // Fullness is checked before the position.
        if (list_len >= CAPACITY) begin
          st = ST_FULL;
        end else if (op == OP_INS_POS && (pos < 1 || pos > list_len)) begin
          st = ST_BADPOS;
        end else begin
          idx = (op == OP_INS_FRONT) ? 0 : (op == OP_INS_BACK) ? list_len : pos - 1;
          for (int i = list_len; i > idx; i--) list_words[i] = list_words[i - 1];
          list_words[idx] = val;
          list_len++;
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else if (op == OP_DEL_POS && (pos < 1 || pos > list_len)) begin
          st = ST_BADPOS;
        end else begin
          idx = (op == OP_DEL_FRONT) ? 0 : (op == OP_DEL_BACK) ? list_len - 1 : pos - 1;
          for (int i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
          list_len--;
        end
      end
      OP_SEARCH: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len && i < 8; i++)
            if (list_words[i] == val) mask[i] = 1'b1;
          if (mask == '0) st = ST_NOTFOUND;
        end
      end
      OP_READOUT: begin
        if (list_len == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i < list_len; i++) begin
            res.status      = ST_OK;
            res.element     = list_words[i];
            res.element_pos = 4'(i + 1);
            res.hit_mask    = '0;
            res.length      = 4'(list_len);
            res.last        = (i + 1 == list_len);
            expected_results.push_back(res);
          end
          return;
        end
      end
      OP_ROTATE: begin
        // A left rotation by the count modulo the length; an empty list is left alone.
        if (list_len > 0) begin
          shift = rot % list_len;
          snap  = list_words;
          for (int i = 0; i < list_len; i++) list_words[i] = snap[(i + shift) % list_len];
        end
      end
      default: begin
      end
    endcase
    res.status      = st;
    res.element     = '0;
    res.element_pos = '0;
    res.hit_mask    = mask;
    res.length      = 4'(list_len);
    res.last        = 1'b1;
    expected_results.push_back(res);
  endtask

  // Presents one command and holds it until the engine takes it. The strobe is left high so
  // that the next command can follow at once; a random gap lowers it for a while.
  task automatic send_list_op(input logic [3:0] op, input logic [31:0] val,
                              input logic [5:0] pos, input logic [15:0] rot);
    start_i        <= 1'b1;
    opcode_i       <= op;
    value_i        <= val;
    position_i     <= pos;
    rotate_count_i <= rot;
    do @(posedge clk_i); while (busy_o);
    predict_list_op(op, val, pos, rot);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // Every command that needs elements, on an empty list; also the positional insert,
  // which can never find a valid position here.
  task automatic test_empty_list();
    send_list_op(OP_DEL_FRONT, '0, 6'd0, '0);
    send_list_op(OP_DEL_BACK,  '0, 6'd0, '0);
    send_list_op(OP_DEL_POS,   '0, 6'd1, '0);
    send_list_op(OP_SEARCH,    '0, 6'd0, '0);
    send_list_op(OP_READOUT,   '0, 6'd0, '0);
    send_list_op(OP_ROTATE,    '0, 6'd0, 16'd5);
    send_list_op(OP_INS_POS,   32'd5, 6'd1, '0);
  endtask

  // Extreme values at both ends, then positional inserts with bad and good positions.
  task automatic test_insert_edges();
    send_list_op(OP_INS_FRONT, 32'h8000_0000, 6'd0, '0);
    send_list_op(OP_INS_BACK,  32'h7fff_ffff, 6'd0, '0);
    send_list_op(OP_INS_POS,   32'd9, 6'd0, '0);
    send_list_op(OP_INS_POS,   32'd9, 6'd3, '0);
    send_list_op(OP_INS_POS,   32'hffff_ffff, 6'd2, '0);
  endtask

  // Fills the list with duplicates, so that a search sets the top bit of the mask, and
  // checks that a full list rejects inserts whatever the position.
  task automatic test_full_list();
    while (list_len < CAPACITY) send_list_op(OP_INS_BACK, 32'h7fff_ffff, 6'd0, '0);
    send_list_op(OP_INS_FRONT, 32'd1, 6'd0, '0);
    send_list_op(OP_INS_POS,   32'd1, 6'd1, '0);
    send_list_op(OP_SEARCH,    32'h7fff_ffff, 6'd0, '0);
  endtask

  // The largest rotate count, deletes at bad and edge positions, a failed search and a
  // read-out of what is left.
  task automatic test_delete_rotate();
    send_list_op(OP_ROTATE,    '0, 6'd0, 16'hffff);
    send_list_op(OP_DEL_POS,   '0, 6'd0, '0);
    send_list_op(OP_DEL_POS,   '0, 6'd63, '0);
    send_list_op(OP_DEL_POS,   '0, 6'(CAPACITY), '0);
    send_list_op(OP_DEL_FRONT, '0, 6'd0, '0);
    send_list_op(OP_DEL_BACK,  '0, 6'd0, '0);
    send_list_op(OP_SEARCH,    32'd12345, 6'd0, '0);
    send_list_op(OP_READOUT,   '0, 6'd0, '0);
  endtask

  // Opcodes above the last one are ignored apart from a plain status item.
  task automatic test_unknown_opcodes();
    send_list_op(FIRST_UNUSED_OP, 32'hdead_beef, 6'h3f, 16'hffff);
    send_list_op(4'hf, '0, 6'd0, '0);
  endtask

  // Random commands. The mix drifts between filling and draining so that the list keeps
  // passing through empty and full; values are often taken from the list or from a small
  // pool, so that searches hit and duplicates build up.
  task automatic test_random_mix(input int n_items, input int idle_pct);
    int          sent;
    int          roll;
    int          ins_weight;
    bit          filling;
    logic [3:0]  op;
    logic [31:0] val;
    logic [5:0]  pos;
    logic [15:0] rot;
    sender_idle_pct = idle_pct;
    sent    = 0;
    filling = 1'b1;
    while (sent < n_items) begin
      if (list_len == CAPACITY) filling = 1'b0;
      else if (list_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = ~filling;
      ins_weight = filling ? 40 : 20;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        op = FIRST_UNUSED_OP + 4'($urandom_range(0, 6));
      end else if (roll < 5 + ins_weight) begin
        case ($urandom_range(0, 2))
          0:       op = OP_INS_FRONT;
          1:       op = OP_INS_BACK;
          default: op = OP_INS_POS;
        endcase
      end else if (roll < 65) begin
        case ($urandom_range(0, 2))
          0:       op = OP_DEL_FRONT;
          1:       op = OP_DEL_BACK;
          default: op = OP_DEL_POS;
        endcase
      end else if (roll < 80) begin
        op = OP_SEARCH;
      end else if (roll < 90) begin
        op = OP_READOUT;
      end else begin
        op = OP_ROTATE;
      end
      case ($urandom_range(0, 3))
        0:       val = $urandom;
        1:       val = (list_len > 0) ? list_words[$urandom_range(0, list_len - 1)] : $urandom;
        2:       val = 32'($urandom_range(0, 3)) - 32'd2;
        default: val = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
      // Mostly a valid position, sometimes anything the field can hold.
      if (list_len == 0 || $urandom_range(0, 4) == 0) pos = 6'($urandom);
      else pos = 6'($urandom_range(1, list_len));
      rot = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 17));
      send_list_op(op, val, pos, rot);
      sent++;
    end
  endtask

  // Result checker: each strobed item is compared with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected result item: status %0d element %h pos %0d mask %h",
                   $realtime, status_o, element_o, element_position_o, hit_mask_o,
                   " len %0d last %0b", length_o, last_o);
      end else begin
        want = expected_results.pop_front();
        if (want.status !== status_o || want.element !== element_o ||
            want.element_pos !== element_position_o || want.hit_mask !== hit_mask_o ||
            want.length !== length_o || want.last !== last_o) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected: status %0d element %h pos %0d mask %h len %0d last %0b",
                     want.status, want.element, want.element_pos, want.hit_mask, want.length,
                     want.last);
            $display("  actual:   status %0d element %h pos %0d mask %h len %0d last %0b",
                     status_o, element_o, element_position_o, hit_mask_o, length_o, last_o);
          end
        end
      end
    end
  end

  // Watchdog: any accepted command or result item restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || res_valid_o || (start_i && !busy_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
      $display("[array_list_engine_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    list_len = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_insert_edges();
    test_full_list();
    test_delete_rotate();
    test_unknown_opcodes();

    // Sender pacing phases: back to back, idle more often than not, back to back again
    // (the receiver cannot stall, so its stalling phase has no idle sender), then idle at times.
    test_random_mix(100, 0);
    test_random_mix(100, 55);
    test_random_mix(100, 0);
    test_random_mix(100, 38);

    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[array_list_engine_top] OK");
    end else begin
      $display("[array_list_engine_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ale_pkg.sv
hw/rtl/ale_ram.sv
hw/rtl/array_list_engine_top.sv
tb/tb_array_list_engine_top.sv
